// ----- design/tlhc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tlhc_pkg
// Shared types and constants for the two-level LRU hot page classifier.
// ============================================================================
package tlhc_pkg;

    localparam int HOT_ENTRIES_DEF       = 64;
    localparam int CANDIDATE_ENTRIES_DEF = 64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] OUTCOME_QUERY   = 2'd0;
    localparam logic [1:0] OUTCOME_REFRESH = 2'd1;
    localparam logic [1:0] OUTCOME_PROMOTE = 2'd2;
    localparam logic [1:0] OUTCOME_NEW     = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [31:0] page_number;
    } req_t;

    typedef struct packed {
        logic        is_hot;
        logic [1:0]  outcome;
        logic        evicted_valid;
        logic [31:0] evicted_page;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
    } dp_cmd_t;

endpackage

// ----- design/two_level_lru_hot_classifier.sv -----
`timescale 1ns / 1ps
// ============================================================================
// two_level_lru_hot_classifier
// Hot/cold page classifier built from a hot LRU list and a candidate LRU list.
// ============================================================================
// Each request runs a compare state, which checks the page against every
// valid entry of both lists in parallel, then an update state, which shifts
// the lists and loads the result register. The next request is taken in the
// update cycle, overlapping the last request's update while results are
// taken promptly; a stalled result holds the block in its update cycle. List
// storage is flip-flop based and needs no clearing after reset: only the two
// fill counts are reset, and entries beyond a count are never compared.
module two_level_lru_hot_classifier #(
    parameter int HOT_ENTRIES       = tlhc_pkg::HOT_ENTRIES_DEF,
    parameter int CANDIDATE_ENTRIES = tlhc_pkg::CANDIDATE_ENTRIES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tlhc_pkg::req_t s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output tlhc_pkg::rsp_t m_rsp
);
    import tlhc_pkg::*;

    dp_cmd_t cmd;

    tlhc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tlhc_datapath #(
        .HOT_ENTRIES       (HOT_ENTRIES),
        .CANDIDATE_ENTRIES (CANDIDATE_ENTRIES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_req   (s_req),
        .m_rsp   (m_rsp)
    );

endmodule

// ----- design/tlhc_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tlhc_datapath
// Request register, parallel lookup of both lists, shifting list storage,
// counts and result register.
// ============================================================================
module tlhc_datapath #(
    parameter int HOT_ENTRIES       = tlhc_pkg::HOT_ENTRIES_DEF,
    parameter int CANDIDATE_ENTRIES = tlhc_pkg::CANDIDATE_ENTRIES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tlhc_pkg::dp_cmd_t cmd,
    input  tlhc_pkg::req_t   s_req,
    output tlhc_pkg::rsp_t   m_rsp
);
    import tlhc_pkg::*;

    localparam int HCW = $clog2(HOT_ENTRIES + 1);
    localparam int CCW = $clog2(CANDIDATE_ENTRIES + 1);

    req_t        req_reg;
    rsp_t        rsp_reg, rsp_next;
    logic [31:0] hot_reg  [HOT_ENTRIES];
    logic [31:0] hot_next [HOT_ENTRIES];
    logic [31:0] cand_reg [CANDIDATE_ENTRIES];
    logic [31:0] cand_next[CANDIDATE_ENTRIES];
    logic [HCW-1:0] hot_count_reg, hot_count_next;
    logic [CCW-1:0] cand_count_reg, cand_count_next;

    logic [HOT_ENTRIES-1:0]       hot_match, hot_after, hot_after_reg;
    logic [CANDIDATE_ENTRIES-1:0] cand_match, cand_after, cand_after_reg;
    logic hot_hit_reg, cand_hit_reg;
    logic hot_full, cand_full;

    assign hot_full  = (hot_count_reg == HCW'(HOT_ENTRIES));
    assign cand_full = (cand_count_reg == CCW'(CANDIDATE_ENTRIES));

    // lookup: match within valid region, then prefix-or marks entries at or
    // after the first match
    always_comb begin
        for (int i = 0; i < HOT_ENTRIES; i++) begin
            hot_match[i] = (HCW'(i) < hot_count_reg) && (hot_reg[i] == req_reg.page_number);
        end
        for (int i = 0; i < CANDIDATE_ENTRIES; i++) begin
            cand_match[i] = (CCW'(i) < cand_count_reg)
                          && (cand_reg[i] == req_reg.page_number);
        end
        hot_after[0] = hot_match[0];
        for (int i = 1; i < HOT_ENTRIES; i++) begin
            hot_after[i] = hot_after[i-1] | hot_match[i];
        end
        cand_after[0] = cand_match[0];
        for (int i = 1; i < CANDIDATE_ENTRIES; i++) begin
            cand_after[i] = cand_after[i-1] | cand_match[i];
        end
    end

    always_comb begin
        for (int i = 0; i < HOT_ENTRIES; i++) begin
            hot_next[i] = hot_reg[i];
        end
        for (int i = 0; i < CANDIDATE_ENTRIES; i++) begin
            cand_next[i] = cand_reg[i];
        end
        hot_count_next         = hot_count_reg;
        cand_count_next        = cand_count_reg;
        rsp_next.is_hot        = hot_hit_reg;
        rsp_next.outcome       = OUTCOME_QUERY;
        rsp_next.evicted_valid = 1'b0;
        rsp_next.evicted_page  = '0;

        if (req_reg.operation == OP_WRITE) begin
            if (hot_hit_reg) begin
                rsp_next.outcome = OUTCOME_REFRESH;
                hot_next[0] = req_reg.page_number;
                for (int i = 1; i < HOT_ENTRIES; i++) begin
                    if (!hot_after_reg[i-1]) begin
                        hot_next[i] = hot_reg[i-1];
                    end
                end
            end else if (cand_hit_reg) begin
                rsp_next.outcome = OUTCOME_PROMOTE;
                hot_next[0] = req_reg.page_number;
                for (int i = 1; i < HOT_ENTRIES; i++) begin
                    hot_next[i] = hot_reg[i-1];
                end
                if (hot_full) begin
                    rsp_next.evicted_valid = 1'b1;
                    rsp_next.evicted_page  = hot_reg[HOT_ENTRIES-1];
                    cand_next[0] = hot_reg[HOT_ENTRIES-1];
                    for (int i = 1; i < CANDIDATE_ENTRIES; i++) begin
                        if (!cand_after_reg[i-1]) begin
                            cand_next[i] = cand_reg[i-1];
                        end
                    end
                end else begin
                    hot_count_next  = hot_count_reg + HCW'(1);
                    cand_count_next = cand_count_reg - CCW'(1);
                    for (int i = 0; i < CANDIDATE_ENTRIES - 1; i++) begin
                        if (cand_after_reg[i]) begin
                            cand_next[i] = cand_reg[i+1];
                        end
                    end
                end
            end else begin
                rsp_next.outcome = OUTCOME_NEW;
                cand_next[0] = req_reg.page_number;
                for (int i = 1; i < CANDIDATE_ENTRIES; i++) begin
                    cand_next[i] = cand_reg[i-1];
                end
                if (cand_full) begin
                    rsp_next.evicted_valid = 1'b1;
                    rsp_next.evicted_page  = cand_reg[CANDIDATE_ENTRIES-1];
                end else begin
                    cand_count_next = cand_count_reg + CCW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_req;
        end
        if (cmd.compare) begin
            hot_hit_reg    <= hot_after[HOT_ENTRIES-1];
            cand_hit_reg   <= cand_after[CANDIDATE_ENTRIES-1];
            hot_after_reg  <= hot_after;
            cand_after_reg <= cand_after;
        end
        if (cmd.update) begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < HOT_ENTRIES; i++) begin
                hot_reg[i] <= hot_next[i];
            end
            for (int i = 0; i < CANDIDATE_ENTRIES; i++) begin
                cand_reg[i] <= cand_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hot_count_reg  <= '0;
            cand_count_reg <= '0;
        end else if (cmd.update) begin
            hot_count_reg  <= hot_count_next;
            cand_count_reg <= cand_count_next;
        end
    end

    assign m_rsp = rsp_reg;

    a_hot_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hot_count_reg <= HCW'(HOT_ENTRIES))
        else $error("hot count above capacity");

    a_cand_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cand_count_reg <= CCW'(CANDIDATE_ENTRIES))
        else $error("candidate count above capacity");

    a_evict_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && rsp_next.evicted_valid) |->
        (rsp_next.outcome == OUTCOME_PROMOTE || rsp_next.outcome == OUTCOME_NEW))
        else $error("eviction reported on refresh or query");

    a_query_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && req_reg.operation == OP_QUERY) |=>
        ($stable(hot_count_reg) && $stable(cand_count_reg)))
        else $error("query changed list counts");

endmodule

// ----- design/tlhc_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tlhc_ctrl
// Sequencer: accept, compare, update; owns the input and result handshakes.
// ============================================================================
module tlhc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tlhc_pkg::dp_cmd_t cmd
);
    import tlhc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free, accept, update;

    assign out_free = !m_valid_reg || m_ready;
    assign update   = (state_reg == ST_UPD) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || update;
    assign accept   = s_valid && s_ready;

    assign cmd.capture = accept;
    assign cmd.compare = (state_reg == ST_CMP);
    assign cmd.update  = update;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (update) begin
                    state_next = accept ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = update ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_update_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_cmp_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_CMP))
        else $error("compare did not follow accepted request");

    a_update_follows_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |=> (state_reg == ST_UPD))
        else $error("update did not follow compare");

endmodule

// ----- tb/sv/hot_class_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hot_class_checker
// Tracks the hot and candidate page lists of the classifier, predicts the
// response to every accepted request and compares it with every accepted
// response, field by field, in order.
// ============================================================================
module hot_class_checker #(
    parameter int HOT_N  = tlhc_pkg::HOT_ENTRIES_DEF,
    parameter int CAND_N = tlhc_pkg::CANDIDATE_ENTRIES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  tlhc_pkg::req_t s_req,
    input  logic           m_valid,
    input  logic           m_ready,
    input  tlhc_pkg::rsp_t m_rsp,
    output int             pending,
    output int             failures
);
    import tlhc_pkg::*;

    logic [31:0] hot_pages  [HOT_N];
    logic [31:0] cand_pages [CAND_N];
    int          hot_n;
    int          cand_n;
    rsp_t        predicted_classes [$];
    int          fail_total = 0;

    function automatic int find_hot(logic [31:0] pg);
        for (int i = 0; i < hot_n; i++) begin
            if (hot_pages[i] == pg) return i;
        end
        return -1;
    endfunction

    function automatic int find_cand(logic [31:0] pg);
        for (int i = 0; i < cand_n; i++) begin
            if (cand_pages[i] == pg) return i;
        end
        return -1;
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // index 0 of each list is the most recent page
    task automatic classify_page(input req_t r, output rsp_t e);
        int          hp;
        int          cp;
        logic [31:0] pg;
        logic [31:0] ev;
        pg = r.page_number;
        hp = find_hot(pg);
        e = '0;
        e.is_hot = (hp >= 0);
        if (r.operation == OP_QUERY) begin
            e.outcome = OUTCOME_QUERY;
        end else if (hp >= 0) begin
            for (int i = hp; i > 0; i--) hot_pages[i] = hot_pages[i-1];
            hot_pages[0] = pg;
            e.outcome = OUTCOME_REFRESH;
        end else begin
            cp = find_cand(pg);
            if (cp >= 0) begin
                for (int i = cp; i < cand_n - 1; i++) cand_pages[i] = cand_pages[i+1];
                cand_n--;
                if (hot_n >= HOT_N) begin
                    // hot list full: its oldest page drops to the candidate front
                    ev = hot_pages[HOT_N-1];
                    e.evicted_valid = 1'b1;
                    e.evicted_page = ev;
                    hot_n = HOT_N - 1;
                    for (int i = cand_n; i > 0; i--) cand_pages[i] = cand_pages[i-1];
                    cand_pages[0] = ev;
                    cand_n++;
                end
                for (int i = hot_n; i > 0; i--) hot_pages[i] = hot_pages[i-1];
                hot_pages[0] = pg;
                hot_n++;
                e.outcome = OUTCOME_PROMOTE;
            end else begin
                if (cand_n >= CAND_N) begin
                    e.evicted_valid = 1'b1;
                    e.evicted_page = cand_pages[CAND_N-1];
                    cand_n = CAND_N - 1;
                end
                for (int i = cand_n; i > 0; i--) cand_pages[i] = cand_pages[i-1];
                cand_pages[0] = pg;
                cand_n++;
                e.outcome = OUTCOME_NEW;
            end
        end
    endtask

    always @(posedge aclk) begin
        rsp_t want;
        rsp_t got;
        if (!aresetn) begin
            hot_n = 0;
            cand_n = 0;
            predicted_classes.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = m_rsp;
                if (predicted_classes.size() == 0) begin
                    fail_total++;
                    $display("%0t: response with no request pending, actual %h", $time, got);
                end else begin
                    want = predicted_classes.pop_front();
                    fail_total += field_diff("is_hot", 32'(want.is_hot), 32'(got.is_hot));
                    fail_total += field_diff("outcome", 32'(want.outcome),
                                             32'(got.outcome));
                    fail_total += field_diff("evicted_valid", 32'(want.evicted_valid),
                                             32'(got.evicted_valid));
                    fail_total += field_diff("evicted_page", want.evicted_page,
                                             got.evicted_page);
                end
            end
            if (s_valid && s_ready) begin
                classify_page(s_req, want);
                predicted_classes.push_back(want);
            end
        end
        pending <= predicted_classes.size();
        failures <= fail_total;
    end

endmodule

// ----- tb/sv/two_level_lru_hot_classifier_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// two_level_lru_hot_classifier_tb
// Drives write and query requests into the hot/cold page classifier with
// bursty traffic and a stalling response side; a checker beside the block
// predicts and compares every response.
// ============================================================================
module two_level_lru_hot_classifier_tb;
    import tlhc_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int SEGMENT      = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int POOL_SIZE    = 256;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_req   = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    rsp_t  m_rsp;

    int    pending;
    int    failures;
    int    hold_reqs   = 0;
    int    hold_seen   = 0;
    int    hold_left   = 0;
    int    rx_mode     = 0;
    int    rx_phase    = 0;
    int    idle_cycles = 0;
    int    burst_left  = 0;
    logic [31:0] page_pool [POOL_SIZE];

    always #1 aclk = ~aclk;

    two_level_lru_hot_classifier u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    hot_class_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_req    (s_req),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_rsp    (m_rsp),
        .pending  (pending),
        .failures (failures)
    );

    // response side: stall pattern is redrawn whenever its random phase runs out
    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (rx_phase == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_phase = $urandom_range(20, 120);
        end
        rx_phase--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (rx_phase % 3 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_req(input logic op, input logic [31:0] page);
        s_req <= '{operation: op, page_number: page};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 16);
        end
    endtask

    task automatic drain_requests();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int          span;
        int          seg;
        logic [31:0] page;
        span = 80;
        for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = $urandom;
        page_pool[0] = 32'h0000_0000;
        page_pool[1] = 32'hFFFF_FFFF;
        page_pool[2] = 32'h8000_0000;
        page_pool[3] = 32'h7FFF_FFFF;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = 6;

        // empty lists, new pages, promotion, refresh, query before/after
        send_req(OP_QUERY, 32'h0000_0000);
        send_req(OP_WRITE, 32'h0000_0000);
        send_req(OP_WRITE, 32'hFFFF_FFFF);
        send_req(OP_QUERY, 32'h0000_0000);
        send_req(OP_QUERY, 32'hFFFF_FFFF);
        send_req(OP_WRITE, 32'h0000_0000);
        send_req(OP_QUERY, 32'h0000_0000);
        send_req(OP_WRITE, 32'h0000_0000);
        send_req(OP_WRITE, 32'hFFFF_FFFF);
        send_req(OP_WRITE, 32'h0000_0000);
        send_req(OP_WRITE, 32'hFFFF_FFFF);
        send_req(OP_QUERY, 32'hFFFF_FFFF);
        send_req(OP_WRITE, 32'h0000_0001);
        send_req(OP_WRITE, 32'h8000_0000);
        send_req(OP_QUERY, 32'h8000_0000);
        send_req(OP_WRITE, 32'h8000_0000);
        send_req(OP_WRITE, 32'h7FFF_FFFF);
        send_req(OP_QUERY, 32'h7FFF_FFFF);
        send_req(OP_WRITE, 32'h0000_0001);
        send_req(OP_QUERY, 32'h1234_5678);
        drain_requests();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT == 0) begin
                seg = n / SEGMENT;
                // fill the hot list first, then overflow the candidate list
                if (seg < 3) begin
                    span = 80;
                end else if (seg == 3) begin
                    span = POOL_SIZE;
                end else if (seg == 4) begin
                    span = 4;
                end else begin
                    case ($urandom_range(0, 4))
                        0: span = 4;
                        1: span = 24;
                        2: span = 80;
                        3: span = 130;
                        default: span = POOL_SIZE;
                    endcase
                end
                if (seg == 2 || seg == 9) hold_reqs++;
                if (seg == 5 || seg == 11) drain_requests();
            end
            if ($urandom_range(0, 15) == 0) begin
                page = $urandom;
            end else begin
                page = page_pool[$urandom_range(0, span - 1)];
            end
            send_req(($urandom_range(0, 3) == 0) ? OP_QUERY : OP_WRITE, page);
        end

        drain_requests();
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- two_level_lru_hot_classifier.f -----
design/tlhc_pkg.sv
design/tlhc_datapath.sv
design/tlhc_ctrl.sv
design/two_level_lru_hot_classifier.sv
tb/sv/hot_class_checker.sv
tb/sv/two_level_lru_hot_classifier_tb.sv
